/* rtl/core/tsda_pkg.sv */
`default_nettype none

package tsda_pkg;

    // Default size of the connection table
    localparam int CONN_ENTRIES_DEF = 256;

    // Request codes
    localparam logic [1:0] REQ_OUT = 2'd0;
    localparam logic [1:0] REQ_IN  = 2'd1;
    localparam logic [1:0] REQ_CLR = 2'd2;

    // One direction's sequence record
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] delta;
        logic [31:0] prev;
        logic        active;
    } seq_rec_t;

    // One table entry: outgoing and incoming records
    typedef struct packed {
        seq_rec_t fwd;
        seq_rec_t rev;
    } conn_entry_t;

    localparam int ENTRY_W = $bits(conn_entry_t);

    // True when a is after b in modulo-2^32 serial arithmetic
    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = b - a;
        return diff[31];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tsda_ram.sv */
`default_nettype none

module tsda_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tcp_seq_delta_adjuster.sv */
`default_nettype none
// An accepted transaction reads its connection entry from the single table RAM, is
// computed, and writes any update to the entry back as its result loads into the output
// register; a stalled output holds it there, and no new transaction is accepted until then.
// Reset: control clears at once; the table is then zeroed one entry a cycle, during
// which no transaction is accepted.

module tcp_seq_delta_adjuster #(
    parameter int CONN_ENTRIES = tsda_pkg::CONN_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  conn_id,
    input  wire logic        is_tcp,
    input  wire logic        app_bound,
    input  wire logic [31:0] seq_in,
    input  wire logic [31:0] ack_in,
    input  wire logic signed [16:0] size_change,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [31:0] seq_out,
    output logic      [31:0] ack_out
);

    import tsda_pkg::*;

    localparam int ADDR_W = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
    localparam int IDX_W  = (ADDR_W > 8) ? ADDR_W : 8;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CONN_ENTRIES - 1);
    localparam logic [IDX_W:0]    ENTRIES_X = (IDX_W + 1)'(CONN_ENTRIES);

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_LOOK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    // Captured transaction
    logic [1:0]        req_reg;
    logic              id_ok_reg;
    logic              tcp_reg;
    logic              bound_reg;
    logic [31:0]       seq_reg;
    logic [31:0]       ack_reg;
    logic [16:0]       size_reg;
    logic [ADDR_W-1:0] addr_reg;

    // First compute stage
    seq_rec_t    own_reg;
    seq_rec_t    oth_reg;
    logic        own_after_reg;
    logic [31:0] thr_reg;
    logic [31:0] seq_d_reg;
    logic [31:0] seq_p_reg;
    logic [31:0] ack_d_reg;
    logic [31:0] ack_p_reg;

    // Output register
    logic        out_valid_reg;
    logic [31:0] seq_out_reg;
    logic [31:0] ack_out_reg;

    logic              accept;
    logic              out_free;
    logic [IDX_W-1:0]  id_ext;
    logic              id_ok;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;
    conn_entry_t       rd_entry;
    seq_rec_t          own_rd;
    seq_rec_t          oth_rd;

    logic        adjust;
    logic        clr_hit;
    logic        own_fix;
    logic        oth_fix;
    logic        ack_after;
    logic [31:0] d32;
    logic        upd;
    logic [31:0] seq_res;
    logic [31:0] ack_res;
    seq_rec_t    new_own;
    conn_entry_t wb_entry;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign seq_out   = seq_out_reg;
    assign ack_out   = ack_out_reg;

    // Decode the entry index against the table size
    assign id_ext = IDX_W'(conn_id);
    assign id_ok  = ({1'b0, id_ext} < ENTRIES_X);

    tsda_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (CONN_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (id_ext[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Pick own and other direction from the read entry
    always_comb
    begin
        rd_entry = conn_entry_t'(ram_rd_data);
        if (req_reg == REQ_IN)
        begin
            own_rd = rd_entry.rev;
            oth_rd = rd_entry.fwd;
        end
        else
        begin
            own_rd = rd_entry.fwd;
            oth_rd = rd_entry.rev;
        end
    end

    // Second stage: select the adjusted numbers and build the write-back
    always_comb
    begin
        adjust    = id_ok_reg && tcp_reg && bound_reg
                    && ((req_reg == REQ_OUT) || (req_reg == REQ_IN));
        clr_hit   = id_ok_reg && (req_reg == REQ_CLR);
        own_fix   = own_reg.active && ((own_reg.delta != '0) || (own_reg.prev != '0));
        oth_fix   = oth_reg.active && ((oth_reg.delta != '0) || (oth_reg.prev != '0));
        ack_after = seq_after(ack_reg, thr_reg);
        d32       = {{15{size_reg[16]}}, size_reg};

        seq_res = seq_reg;
        ack_res = ack_reg;
        if (adjust && own_fix)
        begin
            seq_res = own_after_reg ? seq_d_reg : seq_p_reg;
        end
        if (adjust && oth_fix)
        begin
            ack_res = ack_after ? ack_d_reg : ack_p_reg;
        end

        upd = adjust && (size_reg != '0) && (!own_reg.active || own_after_reg);

        new_own.start  = seq_reg;
        new_own.delta  = own_reg.delta + d32;
        new_own.prev   = own_reg.delta;
        new_own.active = 1'b1;

        if (clr_hit)
        begin
            wb_entry = '0;
        end
        else if (req_reg == REQ_IN)
        begin
            wb_entry.fwd = oth_reg;
            wb_entry.rev = new_own;
        end
        else
        begin
            wb_entry.fwd = new_own;
            wb_entry.rev = oth_reg;
        end
    end

    // Table write port: clearing sweep or write-back
    always_comb
    begin
        if (state_reg == S_INIT)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = (state_reg == S_DONE) && out_free && (clr_hit || upd);
            ram_wr_addr = addr_reg;
            ram_wr_data = ENTRY_W'(wb_entry);
        end
    end

    // Sequence the transaction through read, compute and write-back
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_INIT:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            id_ok_reg <= id_ok;
            tcp_reg   <= is_tcp;
            bound_reg <= app_bound;
            seq_reg   <= seq_in;
            ack_reg   <= ack_in;
            size_reg  <= size_change;
            addr_reg  <= id_ext[ADDR_W-1:0];
        end
    end

    // First stage: serial compare and candidate sums
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK)
        begin
            own_reg       <= own_rd;
            oth_reg       <= oth_rd;
            own_after_reg <= seq_after(seq_reg, own_rd.start);
            thr_reg       <= oth_rd.start + oth_rd.delta;
            seq_d_reg     <= seq_reg + own_rd.delta;
            seq_p_reg     <= seq_reg + own_rd.prev;
            ack_d_reg     <= ack_reg - oth_rd.delta;
            ack_p_reg     <= ack_reg - oth_rd.prev;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            seq_out_reg <= seq_res;
            ack_out_reg <= ack_res;
        end
    end

endmodule

`default_nettype wire
